>>> rtl/core/lam_pkg.sv
// Shared constants, codes and the microcode program of the linear acceleration magnitude core.
package lam_pkg;

    // Fixed field widths.
    localparam int SAMPLE_BITS   = 16;
    localparam int ALPHA_BITS    = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAG_W         = 17;
    localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;

    // Axis bookkeeping.
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ALPHA_BITS;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_ALPHA = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_ALPHA   = 2'd2;
    localparam logic [ALPHA_BITS-1:0] GRAVITY_ALPHA_RESET = 16'd655;
    localparam logic [ALPHA_BITS-1:0] ACCEL_ALPHA_RESET   = 16'd32768;

    // Datapath operations.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_G_DIFF  = 4'd1;
    localparam logic [OP_W-1:0] OP_ACC_LO  = 4'd2;
    localparam logic [OP_W-1:0] OP_ACC_HI  = 4'd3;
    localparam logic [OP_W-1:0] OP_G_UPD   = 4'd4;
    localparam logic [OP_W-1:0] OP_R_DIFF  = 4'd5;
    localparam logic [OP_W-1:0] OP_R_UPD   = 4'd6;
    localparam logic [OP_W-1:0] OP_RR      = 4'd7;
    localparam logic [OP_W-1:0] OP_SUM_ACC = 4'd8;
    localparam logic [OP_W-1:0] OP_SQ_INIT = 4'd9;
    localparam logic [OP_W-1:0] OP_SQ_STEP = 4'd10;
    localparam logic [OP_W-1:0] OP_MAG     = 4'd11;
    localparam logic [OP_W-1:0] OP_DONE    = 4'd12;

    // Multiplier operand selects.
    localparam logic [1:0] MA_GALPHA = 2'd0;
    localparam logic [1:0] MA_AALPHA = 2'd1;
    localparam logic [1:0] MA_RR     = 2'd2;
    localparam logic [1:0] MB_LO     = 2'd0;
    localparam logic [1:0] MB_HI     = 2'd1;
    localparam logic [1:0] MB_RR     = 2'd2;

    // Jump conditions.
    localparam logic [1:0] JMP_NONE  = 2'd0;
    localparam logic [1:0] JMP_AXIS  = 2'd1;
    localparam logic [1:0] JMP_SQ    = 2'd2;
    localparam logic [1:0] JMP_STALL = 2'd3;

    // Program addresses.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_G_DIFF   = 5'd0;
    localparam logic [PC_W-1:0] PC_G_MUL_LO = 5'd1;
    localparam logic [PC_W-1:0] PC_G_MUL_HI = 5'd2;
    localparam logic [PC_W-1:0] PC_G_ACC    = 5'd3;
    localparam logic [PC_W-1:0] PC_G_UPD    = 5'd4;
    localparam logic [PC_W-1:0] PC_R_DIFF   = 5'd5;
    localparam logic [PC_W-1:0] PC_R_MUL_LO = 5'd6;
    localparam logic [PC_W-1:0] PC_R_MUL_HI = 5'd7;
    localparam logic [PC_W-1:0] PC_R_ACC    = 5'd8;
    localparam logic [PC_W-1:0] PC_R_UPD    = 5'd9;
    localparam logic [PC_W-1:0] PC_RR       = 5'd10;
    localparam logic [PC_W-1:0] PC_SQUARE   = 5'd11;
    localparam logic [PC_W-1:0] PC_SUM      = 5'd12;
    localparam logic [PC_W-1:0] PC_SQ_INIT  = 5'd13;
    localparam logic [PC_W-1:0] PC_SQ_STEP  = 5'd14;
    localparam logic [PC_W-1:0] PC_MAG      = 5'd15;
    localparam logic [PC_W-1:0] PC_DONE     = 5'd16;

    // One control word per program step.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            mul_en;
        logic [1:0]      a_sel;
        logic [1:0]      b_sel;
        logic [1:0]      jump;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Control store: per axis the two filters and the square, then the root.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        case (pc)
            PC_G_DIFF:   uc = '{OP_G_DIFF,  1'b0, MA_GALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_G_MUL_LO: uc = '{OP_NOP,     1'b1, MA_GALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_G_MUL_HI: uc = '{OP_ACC_LO,  1'b1, MA_GALPHA, MB_HI, JMP_NONE,  PC_G_DIFF};
            PC_G_ACC:    uc = '{OP_ACC_HI,  1'b0, MA_GALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_G_UPD:    uc = '{OP_G_UPD,   1'b0, MA_GALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_R_DIFF:   uc = '{OP_R_DIFF,  1'b0, MA_AALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_R_MUL_LO: uc = '{OP_NOP,     1'b1, MA_AALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_R_MUL_HI: uc = '{OP_ACC_LO,  1'b1, MA_AALPHA, MB_HI, JMP_NONE,  PC_G_DIFF};
            PC_R_ACC:    uc = '{OP_ACC_HI,  1'b0, MA_AALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_R_UPD:    uc = '{OP_R_UPD,   1'b0, MA_AALPHA, MB_LO, JMP_NONE,  PC_G_DIFF};
            PC_RR:       uc = '{OP_RR,      1'b0, MA_RR,     MB_RR, JMP_NONE,  PC_G_DIFF};
            PC_SQUARE:   uc = '{OP_NOP,     1'b1, MA_RR,     MB_RR, JMP_NONE,  PC_G_DIFF};
            PC_SUM:      uc = '{OP_SUM_ACC, 1'b0, MA_RR,     MB_RR, JMP_AXIS,  PC_G_DIFF};
            PC_SQ_INIT:  uc = '{OP_SQ_INIT, 1'b0, MA_RR,     MB_RR, JMP_NONE,  PC_G_DIFF};
            PC_SQ_STEP:  uc = '{OP_SQ_STEP, 1'b0, MA_RR,     MB_RR, JMP_SQ,    PC_SQ_STEP};
            PC_MAG:      uc = '{OP_MAG,     1'b0, MA_RR,     MB_RR, JMP_NONE,  PC_G_DIFF};
            PC_DONE:     uc = '{OP_DONE,    1'b0, MA_RR,     MB_RR, JMP_STALL, PC_DONE};
            default:     uc = '{OP_DONE,    1'b0, MA_RR,     MB_RR, JMP_STALL, PC_DONE};
        endcase
        return uc;
    endfunction

endpackage

>>> rtl/core/lam_sample_if.sv
// Request channel carrying one three-axis accelerometer sample.
interface lam_sample_if;
    logic valid;
    logic ready;
    logic signed [lam_pkg::SAMPLE_BITS-1:0] accel_x;
    logic signed [lam_pkg::SAMPLE_BITS-1:0] accel_y;
    logic signed [lam_pkg::SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

>>> rtl/core/lam_result_if.sv
// Request channel carrying one magnitude result.
interface lam_result_if;
    logic valid;
    logic ready;
    logic [lam_pkg::MAG_W-1:0] magnitude;
    logic seeded;

    modport source (output valid, output magnitude, output seeded, input ready);
    modport sink (input valid, input magnitude, input seeded, output ready);
endinterface

>>> rtl/core/linear_accel_magnitude_core.sv
// Microcoded gravity removal, residue smoothing and vector magnitude core.
//
// Usage: one request on sample_in carries an accel_x/y/z sample; exactly one
// request on result follows, carrying the held magnitude and the seeded flag.
// Registers are written through cfg_write/cfg_index/cfg_data: 0 enable (a
// write of one restarts seeding), 1 gravity alpha, 2 accel alpha; others are
// ignored. Write only while idle: the core itself does not enforce this.
// Program: a filtered sample runs a 17-step program; the three axes loop over
// steps 0..12 on one shared multiplier, then the square root resolves two
// bits per cycle. The core takes no new sample until the result of the
// last one is loaded. A seeding sample or a sample taken while disabled
// skips the program and goes straight to its final step.
// Reset clears the filters, the held magnitude and the seeded flag, disables
// processing and loads the default alphas. When the receiver stalls, the
// result waits in the output register and the program holds in its last
// step; sample_in stays not ready until the result is loaded.
module linear_accel_magnitude_core #(
    parameter int FRAC_BITS = lam_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lam_sample_if.sink                          sample_in,
    lam_result_if.source                        result,
    input  logic                                cfg_write,
    input  logic [lam_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lam_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int S_W    = lam_pkg::SAMPLE_BITS;
    localparam int A_W    = lam_pkg::ALPHA_BITS;
    localparam int HALF   = FRAC_BITS / 2;
    localparam int G_W    = S_W + FRAC_BITS + 1;
    localparam int R_W    = G_W + 1;
    localparam int R1_W   = R_W + 1;
    localparam int D_W    = R_W + 1;
    localparam int LO_W   = (D_W + 1) / 2;
    localparam int HI_W   = D_W - LO_W;
    localparam int RR_SH  = FRAC_BITS - HALF;
    localparam int RR_W   = R_W - RR_SH;
    localparam int M1     = (A_W + 1 > LO_W + 1) ? A_W + 1 : LO_W + 1;
    localparam int M2     = (M1 > HI_W) ? M1 : HI_W;
    localparam int MUL_W  = (M2 > RR_W) ? M2 : RR_W;
    localparam int P_W    = 2 * MUL_W;
    localparam int ACC_W  = A_W + D_W + 1;
    localparam int SUM_W  = 2 * RR_W;
    localparam int SQ_ITERS = (RR_W + 1) / 2;
    localparam int RT_W   = 2 * SQ_ITERS;
    localparam int RAD_W  = 2 * RT_W;
    localparam int REM_W  = RT_W + 2;
    localparam int CNT_W  = $clog2(SQ_ITERS);
    localparam int MAGF_W = RT_W + 1 - HALF;
    localparam int CMP_W  = (MAGF_W > lam_pkg::MAG_W) ? MAGF_W : lam_pkg::MAG_W;
    localparam int MAG_W  = lam_pkg::MAG_W;

    localparam logic signed [ACC_W-1:0] ACC_ROUND =
        {{(ACC_W - A_W){1'b0}}, 1'b1, {(A_W - 1){1'b0}}};
    localparam logic signed [R1_W-1:0] RR_ROUND =
        {{(R1_W - RR_SH){1'b0}}, 1'b1, {(RR_SH - 1){1'b0}}};
    localparam logic [RT_W:0] MAG_ROUND =
        {{(RT_W + 1 - HALF){1'b0}}, 1'b1, {(HALF - 1){1'b0}}};
    localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(SQ_ITERS - 1);

    // Architectural state.
    logic                        enable_reg, enable_next;
    logic [A_W-1:0]              galpha_reg, galpha_next;
    logic [A_W-1:0]              aalpha_reg, aalpha_next;
    logic signed [G_W-1:0]       g_reg [lam_pkg::AXES];
    logic signed [G_W-1:0]       g_next [lam_pkg::AXES];
    logic signed [R_W-1:0]       rf_reg [lam_pkg::AXES];
    logic signed [R_W-1:0]       rf_next [lam_pkg::AXES];
    logic [MAG_W-1:0]            held_reg, held_next;
    logic                        seeded_reg, seeded_next;

    // Sequencer.
    logic                        busy_reg, busy_next;
    logic [lam_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [lam_pkg::AXIS_W-1:0]  axis_reg, axis_next;
    logic [CNT_W-1:0]            sq_cnt_reg, sq_cnt_next;
    lam_pkg::ucode_t             uc;
    logic                        jump_taken;

    // Working registers.
    logic signed [S_W-1:0]       s_reg [lam_pkg::AXES];
    logic signed [S_W-1:0]       s_next [lam_pkg::AXES];
    logic signed [D_W-1:0]       diff_reg, diff_next;
    logic signed [P_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [RR_W-1:0]      rr_reg, rr_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [RAD_W-1:0]            rad_reg, rad_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [RT_W-1:0]             root_reg, root_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]            out_mag_reg, out_mag_next;
    logic                        out_seed_reg, out_seed_next;

    // Combinational helpers.
    logic                        in_accept;
    logic                        slot_free;
    logic signed [S_W-1:0]       in_s [lam_pkg::AXES];
    logic signed [D_W-1:0]       s_wide;
    logic signed [D_W-1:0]       s_ext;
    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic signed [ACC_W-1:0]     acc_shift;
    logic signed [R1_W-1:0]      rr_wide;
    logic [REM_W-1:0]            rem1, rem2, trial1, trial2;
    logic [RT_W-1:0]             root1, root2;
    logic [RT_W:0]               mag_rnd;
    logic [MAGF_W-1:0]           mag_full;

    assign in_accept = sample_in.valid && sample_in.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign in_s[0]   = sample_in.accel_x;
    assign in_s[1]   = sample_in.accel_y;
    assign in_s[2]   = sample_in.accel_z;
    assign uc        = lam_pkg::ucode_rom(pc_reg);

    assign sample_in.ready  = !busy_reg;
    assign result.valid     = out_valid_reg;
    assign result.magnitude = out_mag_reg;
    assign result.seeded    = out_seed_reg;

    // Jump condition of the current step.
    always_comb
    begin
        case (uc.jump)
            lam_pkg::JMP_NONE:  jump_taken = 1'b0;
            lam_pkg::JMP_AXIS:  jump_taken = (axis_reg != lam_pkg::LAST_AXIS);
            lam_pkg::JMP_SQ:    jump_taken = (sq_cnt_reg != SQ_LAST);
            lam_pkg::JMP_STALL: jump_taken = !slot_free;
            default:            jump_taken = 1'b0;
        endcase
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (uc.a_sel)
            lam_pkg::MA_GALPHA: mul_a = MUL_W'(galpha_reg);
            lam_pkg::MA_AALPHA: mul_a = MUL_W'(aalpha_reg);
            default:            mul_a = MUL_W'(rr_reg);
        endcase
        case (uc.b_sel)
            lam_pkg::MB_LO: mul_b = MUL_W'(diff_reg[LO_W-1:0]);
            lam_pkg::MB_HI: mul_b = MUL_W'(diff_reg >>> LO_W);
            default:        mul_b = MUL_W'(rr_reg);
        endcase
    end

    // Two digits of the square root per cycle.
    always_comb
    begin
        rem1   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial1 = {root_reg, 2'b01};
        if (rem1 >= trial1)
        begin
            rem1  = rem1 - trial1;
            root1 = {root_reg[RT_W-2:0], 1'b1};
        end
        else
        begin
            root1 = {root_reg[RT_W-2:0], 1'b0};
        end
        rem2   = {rem1[REM_W-3:0], rad_reg[RAD_W-3:RAD_W-4]};
        trial2 = {root1, 2'b01};
        if (rem2 >= trial2)
        begin
            rem2  = rem2 - trial2;
            root2 = {root1[RT_W-2:0], 1'b1};
        end
        else
        begin
            root2 = {root1[RT_W-2:0], 1'b0};
        end
    end

    // Sequencer, datapath and configuration next-state logic.
    always_comb
    begin
        enable_next    = enable_reg;
        galpha_next    = galpha_reg;
        aalpha_next    = aalpha_reg;
        g_next         = g_reg;
        rf_next        = rf_reg;
        held_next      = held_reg;
        seeded_next    = seeded_reg;
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        axis_next      = axis_reg;
        sq_cnt_next    = sq_cnt_reg;
        s_next         = s_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rr_next        = rr_reg;
        sum_next       = sum_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        out_mag_next   = out_mag_reg;
        out_seed_next  = out_seed_reg;
        out_valid_next = out_valid_reg && !result.ready;

        s_wide    = D_W'(s_reg[axis_reg]);
        s_ext     = s_wide <<< FRAC_BITS;
        acc_shift = acc_reg >>> A_W;
        rr_wide   = R1_W'(rf_reg[axis_reg]) + RR_ROUND;
        mag_rnd   = {1'b0, root_reg} + MAG_ROUND;
        mag_full  = MAGF_W'(mag_rnd >> HALF);

        if (in_accept)
        begin
            busy_next = 1'b1;
            pc_next   = lam_pkg::PC_DONE;
            axis_next = '0;
            sum_next  = '0;
            s_next    = in_s;
            if (enable_reg && !seeded_reg)
            begin
                // First sample: seed gravity, clear the smoothing filters.
                for (int i = 0; i < lam_pkg::AXES; i++)
                begin
                    g_next[i]  = G_W'(in_s[i]) <<< FRAC_BITS;
                    rf_next[i] = '0;
                end
                held_next   = '0;
                seeded_next = 1'b1;
            end
            else if (enable_reg)
            begin
                pc_next = lam_pkg::PC_G_DIFF;
            end
        end
        else if (busy_reg)
        begin
            pc_next = jump_taken ? uc.target : pc_reg + 1'b1;
            if (uc.mul_en)
            begin
                prod_next = mul_a * mul_b;
            end
            case (uc.op)
                lam_pkg::OP_G_DIFF:
                    diff_next = s_ext - D_W'(g_reg[axis_reg]);
                lam_pkg::OP_ACC_LO:
                    acc_next = ACC_W'(prod_reg) + ACC_ROUND;
                lam_pkg::OP_ACC_HI:
                    acc_next = acc_reg + (ACC_W'(prod_reg) <<< LO_W);
                lam_pkg::OP_G_UPD:
                    g_next[axis_reg] = g_reg[axis_reg] + G_W'(acc_shift);
                lam_pkg::OP_R_DIFF:
                    diff_next = s_ext - D_W'(g_reg[axis_reg]) - D_W'(rf_reg[axis_reg]);
                lam_pkg::OP_R_UPD:
                    rf_next[axis_reg] = rf_reg[axis_reg] + R_W'(acc_shift);
                lam_pkg::OP_RR:
                    rr_next = RR_W'(rr_wide >>> RR_SH);
                lam_pkg::OP_SUM_ACC:
                begin
                    sum_next  = sum_reg + SUM_W'(prod_reg);
                    axis_next = (axis_reg == lam_pkg::LAST_AXIS) ? '0 : axis_reg + 1'b1;
                end
                lam_pkg::OP_SQ_INIT:
                begin
                    rad_next    = RAD_W'(sum_reg);
                    rem_next    = '0;
                    root_next   = '0;
                    sq_cnt_next = '0;
                end
                lam_pkg::OP_SQ_STEP:
                begin
                    rad_next    = rad_reg << 4;
                    rem_next    = rem2;
                    root_next   = root2;
                    sq_cnt_next = sq_cnt_reg + 1'b1;
                end
                lam_pkg::OP_MAG:
                begin
                    if (CMP_W'(mag_full) > CMP_W'(lam_pkg::MAG_MAX))
                    begin
                        held_next = lam_pkg::MAG_MAX;
                    end
                    else
                    begin
                        held_next = MAG_W'(mag_full);
                    end
                end
                lam_pkg::OP_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_mag_next   = held_reg;
                        out_seed_next  = seeded_reg;
                        busy_next      = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Register writes.
        if (cfg_write)
        begin
            case (cfg_index)
                lam_pkg::CFG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    if (cfg_data[0])
                    begin
                        seeded_next = 1'b0;
                    end
                end
                lam_pkg::CFG_GRAVITY_ALPHA: galpha_next = cfg_data[A_W-1:0];
                lam_pkg::CFG_ACCEL_ALPHA:   aalpha_next = cfg_data[A_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            galpha_reg    <= lam_pkg::GRAVITY_ALPHA_RESET;
            aalpha_reg    <= lam_pkg::ACCEL_ALPHA_RESET;
            for (int i = 0; i < lam_pkg::AXES; i++)
            begin
                g_reg[i]  <= '0;
                rf_reg[i] <= '0;
            end
            held_reg      <= '0;
            seeded_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            pc_reg        <= lam_pkg::PC_G_DIFF;
            axis_reg      <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            galpha_reg    <= galpha_next;
            aalpha_reg    <= aalpha_next;
            g_reg         <= g_next;
            rf_reg        <= rf_next;
            held_reg      <= held_next;
            seeded_reg    <= seeded_next;
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            axis_reg      <= axis_next;
            sq_cnt_reg    <= sq_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rr_reg       <= rr_next;
        sum_reg      <= sum_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        out_mag_reg  <= out_mag_next;
        out_seed_reg <= out_seed_next;
    end

    // A new result appears only out of the final program step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(busy_reg && pc_reg == lam_pkg::PC_DONE))
        else $error("result raised outside the final step");

    // The program ends only by loading a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> result.valid)
        else $error("program ended without a result");

    // The step counter never leaves the program.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= lam_pkg::PC_DONE)
        else $error("step counter outside the program");

endmodule
